[src/sffl_pkg.sv]
// shared types, constants and helpers for the stuffed frame flash loader
package sffl_pkg;

    localparam int unsigned FRAME_BYTES = 8;
    localparam int unsigned HEADER_SKIP_DEFAULT = 16;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE = 8'h7D;
    localparam logic [7:0] ESC_XOR = 8'h20;
    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] TX_SYNC = 8'h5E;
    localparam logic [7:0] HEAD_BYTE = 8'h50;

    localparam logic [7:0] CMD_POWER_UP = 8'h00;
    localparam logic [7:0] CMD_VERSION = 8'h01;
    localparam logic [7:0] CMD_DL_START = 8'h03;
    localparam logic [7:0] CMD_DATA = 8'h04;
    localparam logic [7:0] CMD_EOF = 8'h05;

    localparam logic [7:0] RSP_POWER_UP = 8'h80;
    localparam logic [7:0] RSP_VERSION = 8'h81;
    localparam logic [7:0] RSP_OFFSET = 8'h82;
    localparam logic [7:0] RSP_EOF = 8'h83;
    localparam logic [7:0] RSP_CRC_ERR = 8'h84;

    localparam logic [1:0] KIND_TX = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic CFG_FLASH_BASE = 1'b0;
    localparam logic CFG_PAGE_LOG2 = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WANT_FF,
        PH_IN,
        PH_ESC
    } rx_phase_t;

    typedef enum logic [3:0] {
        ST_RX,
        ST_CRC_IN,
        ST_DECIDE,
        ST_ERASE,
        ST_WRITE,
        ST_RSP_CRC,
        ST_TX_FLAG,
        ST_TX_SYNC,
        ST_TX_BYTE,
        ST_TX_ESC
    } ctrl_state_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_REPLY,
        ACT_DATA
    } action_t;

    // controller to datapath
    typedef struct packed {
        logic       crc_clear;
        logic       crc_step_in;
        logic       crc_step_rsp;
        logic       load_reply;
        logic       apply_frame;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_esc;
        logic       emit_flag;
        logic       emit_sync;
        logic       emit_last;
        logic       byte_next;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       frame_done;
        logic       bypass;
        logic       crc_ok;
        logic       head_ok;
        action_t    action;
        logic       past_skip;
        logic       do_erase;
        logic       byte_needs_esc;
        logic       byte_last;
        logic       crc_last;
    } dp_sts_t;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [7:0] t;
        t = c[15:8] ^ b;
        t = t ^ {4'd0, t[7:4]};
        return {c[7:0], 8'd0} ^ {t[3:0], 12'd0} ^ {3'd0, t, 5'd0} ^ {8'd0, t};
    endfunction

endpackage

[src/sffl_datapath.sv]
// receive unstuffing, frame store, crc unit, loader state and result register
module sffl_datapath import sffl_pkg::*; #(
    parameter int unsigned HEADER_SKIP = HEADER_SKIP_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        rx_fire,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_fire,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    output logic [1:0]  res_kind,
    output logic [7:0]  res_tx_byte,
    output logic [31:0] res_flash_address,
    output logic [31:0] res_flash_word,
    output logic        res_update_active,
    output logic        res_last
);

    rx_phase_t   phase_reg, phase_next;
    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  store_reg [FRAME_BYTES];
    logic        done_reg, done_next;
    logic        bypass_reg, bypass_next;
    logic [31:0] base_reg;
    logic [4:0]  page_reg;
    logic [31:0] offset_reg;
    logic        loading_reg;
    logic [15:0] crc_reg;
    logic [2:0]  ptr_reg;
    logic [7:0]  rsp_code_reg;
    logic [31:0] rsp_pay_reg;

    logic [7:0]  unstuffed;
    logic        escaped;
    logic [3:0]  idx_inc;
    logic [7:0]  cur_in;
    logic [7:0]  rsp_byte;
    logic [31:0] word;
    logic [31:0] tgt;
    logic [31:0] mask;
    logic [31:0] off_plus;
    logic        past_skip;

    assign escaped = (phase_reg == PH_ESC);
    assign unstuffed = escaped ? (rx_byte ^ ESC_XOR) : rx_byte;
    assign idx_inc = idx_reg + 4'd1;

    always_comb begin
        phase_next = phase_reg;
        idx_next = idx_reg;
        done_next = 1'b0;
        bypass_next = bypass_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (rx_byte == FLAG_BYTE) begin
                    phase_next = PH_WANT_FF;
                end
            end
            PH_WANT_FF: begin
                if (rx_byte == SYNC_BYTE) begin
                    phase_next = PH_IN;
                    idx_next = 4'd0;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                if (rx_byte == FLAG_BYTE) begin
                    phase_next = PH_WANT_FF;
                    idx_next = 4'd0;
                end else if (phase_reg == PH_IN && rx_byte == ESC_BYTE) begin
                    phase_next = PH_ESC;
                end else begin
                    idx_next = idx_inc;
                    phase_next = PH_IN;
                    if (idx_inc >= 4'(FRAME_BYTES) ||
                        (idx_inc == 4'd7 && rx_byte == SYNC_BYTE)) begin
                        phase_next = PH_IDLE;
                        idx_next = 4'd0;
                        done_next = 1'b1;
                        bypass_next = (rx_byte == SYNC_BYTE) &&
                                      (idx_inc == 4'd7 || !escaped);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            idx_reg <= 4'd0;
            done_reg <= 1'b0;
            bypass_reg <= 1'b0;
        end else if (rx_fire) begin
            phase_reg <= phase_next;
            idx_reg <= idx_next;
            done_reg <= done_next;
            bypass_reg <= bypass_next;
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rx_fire && (phase_reg == PH_IN || phase_reg == PH_ESC) &&
            rx_byte != FLAG_BYTE && !(phase_reg == PH_IN && rx_byte == ESC_BYTE) &&
            idx_reg < 4'(FRAME_BYTES)) begin
            store_reg[idx_reg[2:0]] <= unstuffed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= 32'd0;
            page_reg <= 5'd10;
        end else if (cfg_fire) begin
            case (cfg_index)
                CFG_FLASH_BASE: base_reg <= cfg_data;
                CFG_PAGE_LOG2: page_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // reply frame bytes
    always_comb begin
        case (ptr_reg)
            3'd0: rsp_byte = HEAD_BYTE;
            3'd1: rsp_byte = rsp_code_reg;
            3'd2: rsp_byte = rsp_pay_reg[7:0];
            3'd3: rsp_byte = rsp_pay_reg[15:8];
            3'd4: rsp_byte = rsp_pay_reg[23:16];
            3'd5: rsp_byte = rsp_pay_reg[31:24];
            3'd6: rsp_byte = 8'd0;
            default: rsp_byte = crc_reg[15:8];
        endcase
    end

    assign cur_in = store_reg[ptr_reg];
    assign word = {store_reg[5], store_reg[4], store_reg[3], store_reg[2]};
    assign past_skip = (offset_reg >= 32'(HEADER_SKIP));
    assign tgt = base_reg + (offset_reg - 32'(HEADER_SKIP));
    assign mask = (32'd1 << page_reg) - 32'd1;
    assign off_plus = offset_reg + 32'd4;

    always_comb begin
        sts.frame_done = done_reg;
        sts.bypass = bypass_reg;
        sts.crc_ok = (crc_reg[7:0] == store_reg[7]);
        sts.head_ok = (store_reg[0] == HEAD_BYTE);
        sts.action = ACT_NONE;
        case (store_reg[1])
            CMD_POWER_UP, CMD_VERSION, CMD_DL_START, CMD_EOF: sts.action = ACT_REPLY;
            CMD_DATA: begin
                if (store_reg[6] == offset_reg[7:0]) begin
                    sts.action = ACT_DATA;
                end
            end
            default: sts.action = ACT_NONE;
        endcase
        sts.past_skip = past_skip;
        sts.do_erase = past_skip && ((tgt & mask) == 32'd0);
        sts.byte_needs_esc = (rsp_byte == FLAG_BYTE) || (rsp_byte == ESC_BYTE);
        sts.byte_last = (ptr_reg == 3'd7);
        sts.crc_last = (ptr_reg == 3'd6);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= 32'd0;
            loading_reg <= 1'b0;
            ptr_reg <= 3'd0;
        end else begin
            if (cmd.crc_clear) begin
                ptr_reg <= 3'd0;
            end else if (cmd.crc_step_in || cmd.crc_step_rsp || cmd.byte_next) begin
                ptr_reg <= ptr_reg + 3'd1;
            end
            if (cmd.load_reply) begin
                rsp_code_reg <= RSP_CRC_ERR;
                rsp_pay_reg <= 32'd0;
                if (cmd.apply_frame) begin
                    case (store_reg[1])
                        CMD_POWER_UP: rsp_code_reg <= RSP_POWER_UP;
                        CMD_VERSION: begin
                            rsp_code_reg <= RSP_VERSION;
                            loading_reg <= 1'b1;
                        end
                        CMD_DL_START: begin
                            rsp_code_reg <= RSP_OFFSET;
                            offset_reg <= 32'd0;
                        end
                        CMD_DATA: begin
                            rsp_code_reg <= RSP_OFFSET;
                            rsp_pay_reg <= off_plus;
                            offset_reg <= off_plus;
                        end
                        CMD_EOF: begin
                            rsp_code_reg <= RSP_EOF;
                            loading_reg <= 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.crc_clear) begin
            crc_reg <= 16'd0;
        end else if (cmd.crc_step_in) begin
            crc_reg <= crc_step(crc_reg, cur_in);
        end else if (cmd.crc_step_rsp) begin
            crc_reg <= crc_step(crc_reg, rsp_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            res_kind <= cmd.emit_kind;
            res_last <= cmd.emit_last;
            res_update_active <= loading_reg;
            res_tx_byte <= 8'd0;
            res_flash_address <= 32'd0;
            res_flash_word <= 32'd0;
            case (cmd.emit_kind)
                KIND_ERASE: res_flash_address <= tgt;
                KIND_WRITE: begin
                    res_flash_address <= tgt;
                    res_flash_word <= word;
                end
                default: begin
                    if (cmd.emit_flag) begin
                        res_tx_byte <= FLAG_BYTE;
                    end else if (cmd.emit_sync) begin
                        res_tx_byte <= TX_SYNC;
                    end else if (cmd.emit_esc) begin
                        res_tx_byte <= ESC_BYTE;
                    end else if (sts.byte_needs_esc) begin
                        res_tx_byte <= rsp_byte ^ ESC_XOR;
                    end else begin
                        res_tx_byte <= rsp_byte;
                    end
                end
            endcase
        end
    end

endmodule

[src/sffl_ctrl.sv]
// sequencing of frame check, flash requests and reply serialisation
module sffl_ctrl import sffl_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    m_busy,
    input  dp_sts_t sts,
    output dp_cmd_t cmd,
    output logic    s_ready,
    output logic    out_valid_set
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RX;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        out_valid_set = 1'b0;
        case (state_reg)
            ST_RX: begin
                s_ready = 1'b1;
                if (sts.frame_done) begin
                    s_ready = 1'b0;
                    cmd.crc_clear = 1'b1;
                    state_next = ST_CRC_IN;
                end
            end
            ST_CRC_IN: begin
                cmd.crc_step_in = 1'b1;
                if (sts.crc_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!sts.bypass && !sts.crc_ok) begin
                    cmd.load_reply = 1'b1;
                    cmd.crc_clear = 1'b1;
                    state_next = ST_RSP_CRC;
                end else if (!sts.head_ok || sts.action == ACT_NONE) begin
                    state_next = ST_RX;
                end else if (sts.action == ACT_DATA && sts.do_erase) begin
                    state_next = ST_ERASE;
                end else if (sts.action == ACT_DATA && sts.past_skip) begin
                    state_next = ST_WRITE;
                end else begin
                    cmd.load_reply = 1'b1;
                    cmd.apply_frame = 1'b1;
                    cmd.crc_clear = 1'b1;
                    state_next = ST_RSP_CRC;
                end
            end
            ST_ERASE: begin
                if (!m_busy) begin
                    cmd.emit = 1'b1;
                    cmd.emit_kind = KIND_ERASE;
                    out_valid_set = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (!m_busy) begin
                    cmd.emit = 1'b1;
                    cmd.emit_kind = KIND_WRITE;
                    out_valid_set = 1'b1;
                    cmd.load_reply = 1'b1;
                    cmd.apply_frame = 1'b1;
                    cmd.crc_clear = 1'b1;
                    state_next = ST_RSP_CRC;
                end
            end
            ST_RSP_CRC: begin
                cmd.crc_step_rsp = 1'b1;
                if (sts.crc_last) begin
                    state_next = ST_TX_FLAG;
                end
            end
            ST_TX_FLAG: begin
                if (!m_busy) begin
                    cmd.emit = 1'b1;
                    cmd.emit_flag = 1'b1;
                    // byte pointer wraps from the check byte back to the head byte
                    cmd.byte_next = 1'b1;
                    out_valid_set = 1'b1;
                    state_next = ST_TX_SYNC;
                end
            end
            ST_TX_SYNC: begin
                if (!m_busy) begin
                    cmd.emit = 1'b1;
                    cmd.emit_sync = 1'b1;
                    out_valid_set = 1'b1;
                    state_next = ST_TX_BYTE;
                end
            end
            ST_TX_BYTE: begin
                if (!m_busy) begin
                    cmd.emit = 1'b1;
                    out_valid_set = 1'b1;
                    if (sts.byte_needs_esc) begin
                        cmd.emit_esc = 1'b1;
                        state_next = ST_TX_ESC;
                    end else begin
                        cmd.byte_next = 1'b1;
                        cmd.emit_last = sts.byte_last;
                        if (sts.byte_last) begin
                            state_next = ST_RX;
                        end
                    end
                end
            end
            ST_TX_ESC: begin
                if (!m_busy) begin
                    cmd.emit = 1'b1;
                    out_valid_set = 1'b1;
                    cmd.byte_next = 1'b1;
                    cmd.emit_last = sts.byte_last;
                    state_next = sts.byte_last ? ST_RX : ST_TX_BYTE;
                end
            end
            default: state_next = ST_RX;
        endcase
    end

endmodule

[src/stuffed_frame_flash_loader.sv]
// top level of the stuffed frame flash loader
//  channel | dir | handshake              | payload
//  s_      | in  | s_tvalid/s_tready      | s_tdata: rx_byte
//  m_      | out | m_tvalid/m_tready      | m_tdata, m_tuser, m_tlast
//  cfg_    | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
// a finished frame runs a crc pass over its first seven stored bytes, a decision step,
// up to two flash results and a crc pass over the seven reply bytes, then one result
// per cycle while m_tready is high (up to 20 results)
// aresetn is synchronous, active low; no clearing pass
// s_tready stays low from the end of a frame until its last result is issued or the frame is dropped
// a stalled result holds in the output register and the sequencer waits
module stuffed_frame_flash_loader import sffl_pkg::*; #(
    parameter int unsigned HEADER_SKIP = HEADER_SKIP_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // tx_byte, flash_address, flash_word, update_active, zeros
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic        rdy;
    logic        vset;
    logic        m_valid_reg;
    logic        busy;
    logic [7:0]  tx_b;
    logic [31:0] fa;
    logic [31:0] fw;
    logic        ua;

    assign busy = m_valid_reg && !m_tready;
    assign s_tready = rdy;
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = {7'd0, ua, fw, fa, tx_b};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (vset) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    sffl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .m_busy(busy),
        .sts(sts), .cmd(cmd), .s_ready(rdy), .out_valid_set(vset)
    );

    sffl_datapath #(.HEADER_SKIP(HEADER_SKIP)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .rx_fire(s_tvalid && rdy), .rx_byte(s_tdata),
        .cfg_fire(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .sts(sts), .res_kind(m_tuser), .res_tx_byte(tx_b),
        .res_flash_address(fa), .res_flash_word(fw), .res_update_active(ua),
        .res_last(m_tlast)
    );

endmodule
